// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`endif

// ----- hdl/s3bd_pkg.sv -----
// ---------------------------------------------------------------------------
// s3bd_pkg
// shared types, codes and expansion tables of the block decompressor
// ---------------------------------------------------------------------------
package s3bd_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 24;
    localparam int ADDR_W = 24;
    localparam int ROW_W = 13;
    localparam int PADDR_W = 3;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam logic REG_FORMAT    = 1'b0;
    localparam logic REG_ROW_WIDTH = 1'b1;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 13'd4;

    typedef struct packed {
        logic [1:0]       block_format;
        logic [ROW_W-1:0] row_width;
    } t_cfg;

    typedef struct packed {
        logic [63:0]       color_bits;
        logic [63:0]       alpha_bits;
        logic [9:0]        block_col;
        logic [9:0]        block_row;
        logic [ADDR_W-1:0] layer_base;
    } t_blk;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    typedef logic [7:0] t_exp5 [32];
    typedef logic [7:0] t_exp6 [64];

    // 565 endpoint expansion, floor of v*255/31 and v*255/63
    function automatic t_exp5 build_exp5();
        t_exp5 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'(((i * 8) * 255) / 248);
        end
        return t;
    endfunction

    function automatic t_exp6 build_exp6();
        t_exp6 t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'(((i * 4) * 255) / 252);
        end
        return t;
    endfunction

    localparam t_exp5 EXP5_TABLE = build_exp5();
    localparam t_exp6 EXP6_TABLE = build_exp6();

endpackage

// ----- hdl/s3bd_stream_if.sv -----
// ---------------------------------------------------------------------------
// s3bd stream interfaces
// valid/ready channels for compressed blocks and decoded texels
// ---------------------------------------------------------------------------
interface s3bd_blk_if import s3bd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [63:0]       color_bits;
    logic [63:0]       alpha_bits;
    logic [9:0]        block_col;
    logic [9:0]        block_row;
    logic [ADDR_W-1:0] layer_base;

    modport source (
        output valid, color_bits, alpha_bits, block_col, block_row, layer_base,
        input  ready
    );
    modport sink (
        input  valid, color_bits, alpha_bits, block_col, block_row, layer_base,
        output ready
    );
endinterface

interface s3bd_tex_if import s3bd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [31:0]       texel_color;
    logic [ADDR_W-1:0] texel_address;
    logic              last_texel;

    modport source (
        output valid, texel_color, texel_address, last_texel,
        input  ready
    );
    modport sink (
        input  valid, texel_color, texel_address, last_texel,
        output ready
    );
endinterface

// ----- hdl/s3tc_block_decompressor_core.sv -----
// ---------------------------------------------------------------------------
// s3tc_block_decompressor_core: dxt1/dxt3/dxt5 4x4 block to sixteen texels
// flow: a block is held in the block register and each texel is registered in
//   the texel output register; throughput: one texel per cycle unless the sink
//   stalls, set by the one texel datapath between the two registers
// reset: synchronous active low, clears control, format dxt1, row width 4
// ---------------------------------------------------------------------------
module s3tc_block_decompressor_core import s3bd_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    s3bd_blk_if.sink           i_blk,
    s3bd_tex_if.source         o_tex,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration, to be written only while no block is in flight; the block itself does not enforce this
    t_cfg w_cfg;

    s3bd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // block register and texel counter
    t_blk       r_blk;
    logic       r_busy;
    logic [3:0] r_k;
    logic       n_busy;
    logic [3:0] n_k;

    // texel output register
    logic              r_ovalid;
    logic [31:0]       r_color;
    logic [ADDR_W-1:0] r_addr;
    logic              r_last;
    logic              n_ovalid;

    logic w_accept;
    logic w_advance;
    logic w_final;

    // a texel moves into the output register when that register is free
    // or being drained in the same cycle
    assign w_advance = r_busy && (!r_ovalid || o_tex.ready);
    assign w_final   = w_advance && (r_k == 4'd15);

    // next block enters while the last texel of the current one goes out
    assign i_blk.ready = !r_busy || w_final;
    assign w_accept    = i_blk.valid && i_blk.ready;

    always_comb begin
        n_busy = r_busy;
        n_k    = r_k;
        if (w_advance) begin
            n_k = r_k + 4'd1;
        end
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_final) begin
            n_busy = 1'b0;
        end
        n_ovalid = w_advance ? 1'b1 : (o_tex.ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_k      <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

    // block payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_blk.color_bits <= i_blk.color_bits;
            r_blk.alpha_bits <= i_blk.alpha_bits;
            r_blk.block_col  <= i_blk.block_col;
            r_blk.block_row  <= i_blk.block_row;
            r_blk.layer_base <= i_blk.layer_base;
        end
    end

    // format decode, code three behaves as dxt5
    logic w_dxt1;
    logic w_dxt3;
    assign w_dxt1 = (w_cfg.block_format == FMT_DXT1);
    assign w_dxt3 = (w_cfg.block_format == FMT_DXT3);

    // color index of texel k sits at bits 33+2k:32+2k
    logic [5:0] w_cpos;
    logic [1:0] w_ci;
    assign w_cpos = {1'b1, r_k, 1'b0};
    assign w_ci   = r_blk.color_bits[w_cpos +: 2];

    t_rgba             w_rgba;
    logic [7:0]        w_alpha;
    logic [ADDR_W-1:0] w_addr;

    s3bd_color_sel u_color (
        .i_c0   (r_blk.color_bits[15:0]),
        .i_c1   (r_blk.color_bits[31:16]),
        .i_dxt1 (w_dxt1),
        .i_ci   (w_ci),
        .o_rgba (w_rgba)
    );

    s3bd_alpha_sel u_alpha (
        .i_alpha_bits (r_blk.alpha_bits),
        .i_dxt3       (w_dxt3),
        .i_k          (r_k),
        .o_alpha      (w_alpha)
    );

    // texels in row order: dy from the upper counter bits, dx from the lower
    s3bd_addr_gen #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_addr (
        .i_col       (r_blk.block_col),
        .i_row       (r_blk.block_row),
        .i_dx        (r_k[1:0]),
        .i_dy        (r_k[3:2]),
        .i_base      (r_blk.layer_base),
        .i_row_width (w_cfg.row_width),
        .o_addr      (w_addr)
    );

    logic [31:0] n_color;
    assign n_color = {w_rgba.r, w_rgba.g, w_rgba.b, w_dxt1 ? w_rgba.a : w_alpha};

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_color <= n_color;
            r_addr  <= w_addr;
            r_last  <= (r_k == 4'd15);
        end
    end

    assign o_tex.valid         = r_ovalid;
    assign o_tex.texel_color   = r_color;
    assign o_tex.texel_address = r_addr;
    assign o_tex.last_texel    = r_last;

endmodule

// ----- hdl/s3bd_apb_regs.sv -----
// ---------------------------------------------------------------------------
// s3bd_apb_regs
// apb register file holding block format and row width
// ---------------------------------------------------------------------------
module s3bd_apb_regs import s3bd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // low address bits are byte lanes, register picked by bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_format <= FMT_DXT1;
            r_cfg.row_width    <= ROW_WIDTH_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_FORMAT:    r_cfg.block_format <= pwdata[1:0];
                REG_ROW_WIDTH: r_cfg.row_width    <= pwdata[ROW_W-1:0];
                default:       r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FORMAT:    prdata = {30'd0, r_cfg.block_format};
            REG_ROW_WIDTH: prdata = {{(32-ROW_W){1'b0}}, r_cfg.row_width};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/s3bd_color_sel.sv -----
// ---------------------------------------------------------------------------
// s3bd_color_sel
// expands the 565 endpoints and returns the palette entry of one texel
// ---------------------------------------------------------------------------
module s3bd_color_sel import s3bd_pkg::*; (
    input  logic [15:0] i_c0,
    input  logic [15:0] i_c1,
    input  logic        i_dxt1,
    input  logic [1:0]  i_ci,
    output t_rgba       o_rgba
);

    // floor(x/3) as x*683>>11, exact for x below 768
    localparam logic [19:0] RECIP3 = 20'd683;
    localparam int          RECIP3_SHIFT = 11;

    logic       w_three;
    logic [7:0] w_r0, w_g0, w_b0, w_r1, w_g1, w_b1;

    function automatic logic [7:0] pick(
        input logic [7:0] e0,
        input logic [7:0] e1,
        input logic       three,
        input logic [1:0] ci
    );
        logic [7:0]  heavy;
        logic [7:0]  light;
        logic [9:0]  s;
        logic [19:0] p;
        logic [8:0]  half;
        logic [7:0]  third;
        logic [7:0]  res;
        heavy = (ci == 2'd2) ? e0 : e1;
        light = (ci == 2'd2) ? e1 : e0;
        s     = {1'b0, heavy, 1'b0} + {2'b00, light};
        p     = 20'(s) * RECIP3;
        third = p[RECIP3_SHIFT +: 8];
        half  = {1'b0, e0} + {1'b0, e1};
        unique case (ci)
            2'd0:    res = e0;
            2'd1:    res = e1;
            2'd2:    res = three ? half[8:1] : third;
            default: res = three ? 8'd0 : third;
        endcase
        return res;
    endfunction

    assign w_three = i_dxt1 && (i_c0 <= i_c1);

    assign w_r0 = EXP5_TABLE[i_c0[15:11]];
    assign w_g0 = EXP6_TABLE[i_c0[10:5]];
    assign w_b0 = EXP5_TABLE[i_c0[4:0]];
    assign w_r1 = EXP5_TABLE[i_c1[15:11]];
    assign w_g1 = EXP6_TABLE[i_c1[10:5]];
    assign w_b1 = EXP5_TABLE[i_c1[4:0]];

    assign o_rgba.r = pick(w_r0, w_r1, w_three, i_ci);
    assign o_rgba.g = pick(w_g0, w_g1, w_three, i_ci);
    assign o_rgba.b = pick(w_b0, w_b1, w_three, i_ci);
    // transparent black only in three-color mode
    assign o_rgba.a = (w_three && (i_ci == 2'd3)) ? 8'd0 : 8'hFF;

endmodule

// ----- hdl/s3bd_alpha_sel.sv -----
// ---------------------------------------------------------------------------
// s3bd_alpha_sel
// explicit or interpolated alpha of one texel
// ---------------------------------------------------------------------------
module s3bd_alpha_sel import s3bd_pkg::*; (
    input  logic [63:0] i_alpha_bits,
    input  logic        i_dxt3,
    input  logic [3:0]  i_k,
    output logic [7:0]  o_alpha
);

    // floor(x/7) and floor(x/5) by reciprocal, exact over the blend range
    localparam logic [22:0] RECIP7 = 23'd2341;
    localparam logic [22:0] RECIP5 = 23'd3277;
    localparam int          RECIP_SHIFT = 14;

    logic [5:0]  w_pos3;
    logic [5:0]  w_pos5;
    logic [3:0]  w_a4;
    logic [7:0]  w_a0, w_a1;
    logic [2:0]  w_j, w_w, w_w7, w_w5;
    logic [10:0] w_s7, w_s5;
    logic [22:0] w_p7, w_p5;
    logic [7:0]  w_pal;

    assign w_pos3 = {i_k, 2'b00};
    assign w_pos5 = 6'd16 + {2'b00, i_k} + {1'b0, i_k, 1'b0};

    assign w_a4 = i_alpha_bits[w_pos3 +: 4];
    assign w_a0 = i_alpha_bits[7:0];
    assign w_a1 = i_alpha_bits[15:8];
    assign w_j  = i_alpha_bits[w_pos5 +: 3];

    assign w_w  = w_j - 3'd1;
    assign w_w7 = 3'd7 - w_w;
    assign w_w5 = 3'd5 - w_w;

    assign w_s7 = 11'(w_w7) * 11'(w_a0) + 11'(w_w) * 11'(w_a1);
    assign w_s5 = 11'(w_w5) * 11'(w_a0) + 11'(w_w) * 11'(w_a1);
    assign w_p7 = 23'(w_s7) * RECIP7;
    assign w_p5 = 23'(w_s5) * RECIP5;

    always_comb begin
        priority if (w_j == 3'd0) begin
            w_pal = w_a0;
        end else if (w_j == 3'd1) begin
            w_pal = w_a1;
        end else if (w_a0 > w_a1) begin
            w_pal = w_p7[RECIP_SHIFT +: 8];
        end else if (w_j == 3'd6) begin
            w_pal = 8'd0;
        end else if (w_j == 3'd7) begin
            w_pal = 8'hFF;
        end else begin
            w_pal = w_p5[RECIP_SHIFT +: 8];
        end
    end

    // a4*255/15 is the nibble repeated
    assign o_alpha = i_dxt3 ? {w_a4, w_a4} : w_pal;

endmodule

// ----- hdl/s3bd_addr_gen.sv -----
// ---------------------------------------------------------------------------
// s3bd_addr_gen
// texel address from block position, slice base and row width
// ---------------------------------------------------------------------------
module s3bd_addr_gen import s3bd_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
    input  logic [9:0]        i_col,
    input  logic [9:0]        i_row,
    input  logic [1:0]        i_dx,
    input  logic [1:0]        i_dy,
    input  logic [ADDR_W-1:0] i_base,
    input  logic [ROW_W-1:0]  i_row_width,
    output logic [ADDR_W-1:0] o_addr
);

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? '1 :
        ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    logic [11:0] w_x, w_y;
    logic [24:0] w_prod;
    logic [25:0] w_sum;

    assign w_y    = {i_row, i_dy};
    assign w_x    = {i_col, i_dx};
    assign w_prod = 25'(w_y) * 25'(i_row_width);
    assign w_sum  = 26'(i_base) + 26'(w_prod) + 26'(w_x);
    assign o_addr = w_sum[ADDR_W-1:0] & ADDR_MASK;

endmodule

// ----- hdl/s3bd_checker.sv -----
// ---------------------------------------------------------------------------
// s3bd_checker
// port-level checks of block requests against texel requests
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module s3bd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [5:0] r_pending;
    logic [3:0] r_out_cnt;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // texels owed to the sink and position within the current block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 6'd0;
            r_out_cnt <= 4'd0;
        end else begin
            r_pending <= r_pending + (w_in_acc ? 6'd16 : 6'd0) - (w_out_acc ? 6'd1 : 6'd0);
            if (w_out_acc) begin
                r_out_cnt <= r_out_cnt + 4'd1;
            end
        end
    end

    `ASSERT_PROP(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid,
        "texel request dropped while stalled")
    `ASSERT_PROP(a_last_pos, i_clk, i_rst_n, w_out_acc |-> (i_out_last == (r_out_cnt == 4'd15)),
        "last texel flag out of place")
    `ASSERT_PROP(a_ready_room, i_clk, i_rst_n, i_in_ready |-> (r_pending <= 6'd2),
        "block taken while texels of an earlier block are still owed")
    `ASSERT_NEVER(a_no_phantom, i_clk, i_rst_n, (r_pending == 6'd0) && i_out_valid,
        "texel request with no block outstanding")
    `ASSERT_PROP(a_pending_max, i_clk, i_rst_n, r_pending <= 6'd17,
        "more texels outstanding than the block can hold")

endmodule

bind s3tc_block_decompressor_core s3bd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_blk.valid),
    .i_in_ready  (i_blk.ready),
    .i_out_valid (o_tex.valid),
    .i_out_ready (o_tex.ready),
    .i_out_last  (o_tex.last_texel)
);
